@@ design/array_double_ended_queue_top_assert.svh @@
// Assertion macros shared by the deque checker.
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Concurrent check, sampled on the rising clock, off while reset is active.
`define ADQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("deque check failed");

// Concurrent check that also holds through reset.
`define ADQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("deque check failed");

`endif

@@ design/adq_pkg.sv @@
// Shared types, codes and defaults of the array double-ended queue.
package adq_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // Command selector codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_FRONT = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic                capture;
        logic                wr_rear;
        logic                wr_front_dec;
        logic                wr_front_empty;
        logic                rd_rear;
        logic                rd_front;
        logic                rd_list_first;
        logic                rd_list_next;
        logic                load_code;
        logic                load_data;
        logic                out_last;
        logic [STATUS_W-1:0] code;
    } adq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              full;
        logic              head_zero;
        logic              list_last;
        logic              out_free;
    } adq_stat_t;

endpackage

@@ design/adq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module adq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its value between reads
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/adq_ctrl.sv @@
// Command sequencer of the double-ended queue.
module adq_ctrl import adq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_valid,
    output logic      req_ready,
    input  adq_stat_t stat,
    output adq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = STAT_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (stat.func)
                    FUNC_PUSH_REAR: begin
                        if (stat.out_free) begin
                            cmd.load_code = 1'b1;
                            cmd.out_last  = 1'b1;
                            if (stat.full) begin
                                cmd.code = STAT_FULL;
                            end else begin
                                cmd.wr_rear = 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_PUSH_FRONT: begin
                        if (stat.out_free) begin
                            cmd.load_code = 1'b1;
                            cmd.out_last  = 1'b1;
                            priority if (!stat.head_zero) begin
                                cmd.wr_front_dec = 1'b1;
                            end else if (stat.empty) begin
                                cmd.wr_front_empty = 1'b1;
                            end else begin
                                cmd.code = STAT_NO_FRONT;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_POP_REAR, FUNC_POP_FRONT, FUNC_LIST: begin
                        if (stat.empty) begin
                            if (stat.out_free) begin
                                cmd.load_code = 1'b1;
                                cmd.out_last  = 1'b1;
                                cmd.code      = STAT_EMPTY;
                                state_next    = ST_IDLE;
                            end
                        end else begin
                            cmd.rd_rear       = (stat.func == FUNC_POP_REAR);
                            cmd.rd_front      = (stat.func == FUNC_POP_FRONT);
                            cmd.rd_list_first = (stat.func == FUNC_LIST);
                            state_next        = ST_WAIT;
                        end
                    end
                    default: begin
                        // unused selector: no result
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WAIT: begin
                // read data is ready; emit it and step the listing
                if (stat.out_free) begin
                    cmd.load_data = 1'b1;
                    if (stat.func == FUNC_LIST && !stat.list_last) begin
                        cmd.rd_list_next = 1'b1;
                    end else begin
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/adq_dp.sv @@
// Datapath of the double-ended queue: indices, slot memory, result register.
module adq_dp import adq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  adq_cmd_t              cmd,
    output adq_stat_t             stat,
    input  logic [FUNC_W-1:0]     in_func,
    input  logic [DATA_WIDTH-1:0] in_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_data,
    output logic [STATUS_W-1:0]   out_status,
    output logic                  out_last
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DEPTH + 1);

    logic [FUNC_W-1:0]     func_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [IDX_W-1:0]      list_reg, list_next;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_last_reg;

    logic [IDX_W-1:0]      head_m1, head_p1, tail_m1, tail_p1, list_p1;
    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  out_free;

    assign head_m1 = head_reg - IDX_W'(1);
    assign head_p1 = head_reg + IDX_W'(1);
    assign tail_m1 = tail_reg - IDX_W'(1);
    assign tail_p1 = tail_reg + IDX_W'(1);
    assign list_p1 = list_reg + IDX_W'(1);

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= in_func;
            value_reg <= in_value;
        end
    end

    // Index updates
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        list_next = list_reg;
        if (cmd.wr_rear) begin
            tail_next = tail_p1;
        end
        if (cmd.wr_front_dec) begin
            head_next = head_m1;
        end
        if (cmd.wr_front_empty) begin
            head_next = '0;
            tail_next = IDX_W'(1);
        end
        if (cmd.rd_rear) begin
            if (tail_m1 == head_reg) begin
                head_next = '0;
                tail_next = '0;
            end else begin
                tail_next = tail_m1;
            end
        end
        if (cmd.rd_front) begin
            if (head_p1 == tail_reg) begin
                head_next = '0;
                tail_next = '0;
            end else begin
                head_next = head_p1;
            end
        end
        if (cmd.rd_list_first) begin
            list_next = head_reg;
        end
        if (cmd.rd_list_next) begin
            list_next = list_p1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        list_reg <= list_next;
    end

    // Slot memory addressing
    assign ram_we = cmd.wr_rear | cmd.wr_front_dec | cmd.wr_front_empty;
    assign ram_re = cmd.rd_rear | cmd.rd_front | cmd.rd_list_first | cmd.rd_list_next;

    always_comb begin
        priority if (cmd.wr_rear) begin
            ram_waddr = tail_reg[ADDR_W-1:0];
        end else if (cmd.wr_front_dec) begin
            ram_waddr = head_m1[ADDR_W-1:0];
        end else begin
            ram_waddr = '0;
        end
    end

    always_comb begin
        priority if (cmd.rd_rear) begin
            ram_raddr = tail_m1[ADDR_W-1:0];
        end else if (cmd.rd_list_next) begin
            ram_raddr = list_p1[ADDR_W-1:0];
        end else begin
            ram_raddr = head_reg[ADDR_W-1:0];
        end
    end

    adq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_code || cmd.load_data) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_code) begin
            out_data_reg   <= '0;
            out_status_reg <= cmd.code;
            out_last_reg   <= cmd.out_last;
        end else if (cmd.load_data) begin
            out_data_reg   <= ram_rdata;
            out_status_reg <= STAT_OK;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // Status to the controller
    assign stat.func      = func_reg;
    assign stat.empty     = (tail_reg <= head_reg);
    assign stat.full      = (tail_reg == IDX_W'(DEPTH));
    assign stat.head_zero = (head_reg == '0);
    assign stat.list_last = (list_p1 == tail_reg);
    assign stat.out_free  = out_free;

endmodule

@@ design/array_double_ended_queue_top.sv @@
// Top level of the array double-ended queue.
// Double-ended queue in a linear array of DEPTH words with front and end
// indices; no wraparound, and both indices return to zero when it empties.
// One request is handled at a time: a push steps through accept and
// execute, a pop through accept, memory read and result, a list through
// accept and read, then one element per cycle while the output is free, as
// all reads go through the single registered read port of the slot memory.
// A finished result waits in an output register, so the next request is
// accepted while it is still pending. Slots need no clearing after reset.
module array_double_ended_queue_top import adq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DATA_WIDTH + 7) / 8)*8-1:0] s_tdata,  // push_value
    input  logic [FUNC_W-1:0]                   s_tuser,  // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((DATA_WIDTH + 7) / 8)*8-1:0] m_tdata,  // data_value
    output logic [STATUS_W-1:0]                 m_tuser,  // status
    output logic                                m_tlast
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    adq_cmd_t              cmd;
    adq_stat_t             stat;
    logic [DATA_WIDTH-1:0] out_data;

    adq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    adq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_tuser),
        .in_value   (s_tdata[DATA_WIDTH-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    // Zero-fill the result word to whole bytes
    assign m_tdata = TDATA_W'(out_data);

endmodule

@@ design/adq_checker.sv @@
// Port-level checker of the double-ended queue and its bind.
`include "array_double_ended_queue_top_assert.svh"

module adq_checker import adq_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((DATA_WIDTH + 7) / 8)*8-1:0] m_tdata,
    input logic [STATUS_W-1:0]                 m_tuser,
    input logic                                m_tlast
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    // Whole result word as seen on the master side
    logic [TDATA_W+STATUS_W:0] m_word;

    assign m_word = {m_tdata, m_tuser, m_tlast};

    // A held result keeps its contents
    `ADQ_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_word))

    // Error results carry zero data
    `ADQ_ASSERT(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))

    // Error results always end their request
    `ADQ_ASSERT(a_err_last, aclk, aresetn, m_tvalid && (m_tuser != STAT_OK) |-> m_tlast)

    // One request in flight: the input is closed after an acceptance
    `ADQ_ASSERT(a_one_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)

    // No result right out of reset
    `ADQ_ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_tvalid)

endmodule

bind array_double_ended_queue_top adq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_adq_checker (.*);
